/* design/kfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kfd_pkg;

    localparam int MaxRes   = 5;
    localparam int CntW     = 3;
    localparam int PaddrW   = 4;
    localparam int PdataW   = 32;

    // register indexes, at byte address 4*index
    localparam logic [1:0] REG_KISS_OFF    = 2'd0;
    localparam logic [1:0] REG_RAW_PREFIX  = 2'd1;
    localparam logic [1:0] REG_REBOOT_CODE = 2'd2;
    localparam logic [7:0] REBOOT_RESET    = 8'hFE;

    localparam logic [7:0] FEND      = 8'hC0;
    localparam logic [7:0] FESC      = 8'hDB;
    localparam logic [7:0] TFEND     = 8'hDC;
    localparam logic [7:0] TFESC     = 8'hDD;
    localparam logic [7:0] CMD_DATA  = 8'h00;
    localparam logic [7:0] CMD_P     = 8'h02;
    localparam logic [7:0] CMD_SLOT  = 8'h03;
    localparam logic [7:0] CMD_HW    = 8'h06;
    localparam logic [7:0] PREFIX_0  = 8'h3C;
    localparam logic [7:0] PREFIX_1  = 8'hFF;
    localparam logic [7:0] PREFIX_2  = 8'h01;
    localparam logic [7:0] NEWLINE   = 8'h0A;

    localparam logic [2:0] ST_START = 3'd0;
    localparam logic [2:0] ST_END   = 3'd1;
    localparam logic [2:0] ST_CMD   = 3'd2;
    localparam logic [2:0] ST_P     = 3'd3;
    localparam logic [2:0] ST_SLOT  = 3'd4;
    localparam logic [2:0] ST_DATA  = 3'd5;
    localparam logic [2:0] ST_ESC   = 3'd6;

    localparam logic [1:0] PT_NONE   = 2'd0;
    localparam logic [1:0] PT_DATA   = 2'd1;
    localparam logic [1:0] PT_CTRL   = 2'd2;
    localparam logic [1:0] PT_REBOOT = 2'd3;

    localparam logic [3:0] K_BEGIN    = 4'd0;
    localparam logic [3:0] K_DATA     = 4'd1;
    localparam logic [3:0] K_END      = 4'd2;
    localparam logic [3:0] K_CTRL     = 4'd3;
    localparam logic [3:0] K_CTRL_END = 4'd4;
    localparam logic [3:0] K_REBOOT   = 4'd5;
    localparam logic [3:0] K_SET_P    = 4'd6;
    localparam logic [3:0] K_SET_SLOT = 4'd7;
    localparam logic [3:0] K_REFUSED  = 4'd8;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] value;
    } t_res;

    typedef struct packed {
        logic       kiss_off;
        logic       raw_prefix_on;
        logic [7:0] reboot_code;
    } t_cfg;

    typedef struct packed {
        logic [2:0] parse_state;
        logic [1:0] payload_type;
        logic       raw_idle;
    } t_state;

    typedef struct packed {
        t_state                  nxt;
        logic [CntW-1:0]         cnt;
        t_res [MaxRes-1:0]       res;
    } t_dec;

endpackage

`default_nettype wire

/* design/kfd_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface kfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       rig_ready;

    modport source (output valid, output rx_byte, output rig_ready, input ready);
    modport sink (input valid, input rx_byte, input rig_ready, output ready);
endinterface

`default_nettype wire

/* design/kfd_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface kfd_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic [7:0] value;
    logic       last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink (input valid, input kind, input value, input last, output ready);
endinterface

`default_nettype wire

/* design/kfd_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

module kfd_parser (
    input  wire logic [7:0]     i_rx_byte,
    input  wire logic           i_rig_ready,
    input  kfd_pkg::t_cfg       i_cfg,
    input  kfd_pkg::t_state     i_st,
    output kfd_pkg::t_dec       o_dec
);
    import kfd_pkg::*;

    function automatic t_res mk(input logic [3:0] k, input logic [7:0] v);
        t_res r;
        r.kind  = k;
        r.value = v;
        return r;
    endfunction

    t_res line_res;
    t_res pay_res;
    logic pay_on;
    logic is_nl;

    always_comb begin
        is_nl    = (i_rx_byte == NEWLINE);
        line_res = is_nl ? mk(K_END, 8'h00) : mk(K_DATA, i_rx_byte);
        pay_on   = (i_st.payload_type == PT_DATA) || (i_st.payload_type == PT_CTRL);
        pay_res  = mk((i_st.payload_type == PT_DATA) ? K_DATA : K_CTRL, 8'h00);
    end

    always_comb begin
        o_dec.nxt = i_st;
        o_dec.cnt = '0;
        o_dec.res = '0;
        if (i_cfg.kiss_off) begin
            if (i_st.raw_idle && !i_rig_ready) begin
                o_dec.res[0] = mk(K_REFUSED, 8'h00);
                o_dec.cnt    = CntW'(1);
            end else begin
                o_dec.nxt.raw_idle = is_nl;
                if (i_st.raw_idle) begin
                    o_dec.res[0] = mk(K_BEGIN, 8'h00);
                    if (i_cfg.raw_prefix_on) begin
                        o_dec.res[1] = mk(K_DATA, PREFIX_0);
                        o_dec.res[2] = mk(K_DATA, PREFIX_1);
                        o_dec.res[3] = mk(K_DATA, PREFIX_2);
                        o_dec.res[4] = line_res;
                        o_dec.cnt    = CntW'(5);
                    end else begin
                        o_dec.res[1] = line_res;
                        o_dec.cnt    = CntW'(2);
                    end
                end else begin
                    o_dec.res[0] = line_res;
                    o_dec.cnt    = CntW'(1);
                end
            end
        end else begin
            unique case (i_st.parse_state)
                ST_START: begin
                    if (i_rx_byte == FEND) o_dec.nxt.parse_state = ST_CMD;
                end
                ST_END: begin
                    if (i_rx_byte == FEND) o_dec.nxt.parse_state = ST_START;
                end
                ST_CMD: begin
                    // reboot code is matched after data and hardware commands
                    if (i_rx_byte == CMD_DATA) begin
                        if (!i_rig_ready) begin
                            o_dec.res[0] = mk(K_REFUSED, 8'h00);
                        end else begin
                            o_dec.res[0] = mk(K_BEGIN, 8'h00);
                            o_dec.nxt.parse_state  = ST_DATA;
                            o_dec.nxt.payload_type = PT_DATA;
                        end
                        o_dec.cnt = CntW'(1);
                    end else if (i_rx_byte == CMD_HW) begin
                        o_dec.nxt.parse_state  = ST_DATA;
                        o_dec.nxt.payload_type = PT_CTRL;
                    end else if (i_rx_byte == i_cfg.reboot_code) begin
                        o_dec.nxt.parse_state  = ST_DATA;
                        o_dec.nxt.payload_type = PT_REBOOT;
                    end else if (i_rx_byte == CMD_P) begin
                        o_dec.nxt.parse_state = ST_P;
                    end else if (i_rx_byte == CMD_SLOT) begin
                        o_dec.nxt.parse_state = ST_SLOT;
                    end else if (i_rx_byte != FEND) begin
                        o_dec.nxt.parse_state = ST_END;
                    end
                end
                ST_P: begin
                    o_dec.res[0] = mk(K_SET_P, i_rx_byte);
                    o_dec.cnt    = CntW'(1);
                    o_dec.nxt.parse_state = ST_END;
                end
                ST_SLOT: begin
                    o_dec.res[0] = mk(K_SET_SLOT, i_rx_byte);
                    o_dec.cnt    = CntW'(1);
                    o_dec.nxt.parse_state = ST_END;
                end
                ST_DATA: begin
                    if (i_rx_byte == FESC) begin
                        o_dec.nxt.parse_state = ST_ESC;
                    end else if (i_rx_byte == FEND) begin
                        o_dec.nxt.parse_state = ST_START;
                        if (i_st.payload_type != PT_NONE) begin
                            o_dec.cnt = CntW'(1);
                            if (i_st.payload_type == PT_DATA)
                                o_dec.res[0] = mk(K_END, 8'h00);
                            else if (i_st.payload_type == PT_CTRL)
                                o_dec.res[0] = mk(K_CTRL_END, 8'h00);
                            else
                                o_dec.res[0] = mk(K_REBOOT, 8'h00);
                        end
                    end else if (pay_on) begin
                        o_dec.res[0] = mk(pay_res.kind, i_rx_byte);
                        o_dec.cnt    = CntW'(1);
                    end
                end
                ST_ESC: begin
                    // a fend after fesc is dropped and the escape stays pending
                    if (i_rx_byte == TFEND || i_rx_byte == TFESC) begin
                        o_dec.nxt.parse_state = ST_DATA;
                        if (pay_on) begin
                            o_dec.res[0] = mk(pay_res.kind,
                                              (i_rx_byte == TFEND) ? FEND : FESC);
                            o_dec.cnt    = CntW'(1);
                        end
                    end else if (i_rx_byte != FEND) begin
                        o_dec.nxt.parse_state = ST_END;
                    end
                end
                default: begin
                    o_dec.nxt.parse_state = ST_START;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* design/kiss_frame_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// kiss / raw-line deframer for a serial host link
// input channel: one received byte per item plus the radio's rig_ready flag
// output channel: event items (kind, value, last); last marks the final item
// caused by one input byte
// the first result of a byte shows on the output in the cycle after the byte
// is taken; results leave a five-entry result register one per cycle unless stalled
// throughput: one byte per cycle while each byte gives at most one result and
// the receiver is ready; a raw line start gives two results (five with the
// prefix on) and holds off the input until the single output port has drained
// the result register down to its last result
// bytes that give no result leave nothing behind and are taken every cycle
// while the result register is empty; when the receiver stalls, results wait in
// the result register and the input is held off while any result is waiting
// reset: parser in wait-for-fend, no raw line open, result register empty,
// kiss_off = 0, raw_prefix_on = 0, reboot_code = 0xfe
// configuration: apb writes at byte address 4*index, zero wait states
module kiss_frame_decoder (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    kfd_in_if.sink                          i_in,
    kfd_out_if.source                       o_out,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [kfd_pkg::PaddrW-1:0] paddr,
    input  wire logic [kfd_pkg::PdataW-1:0] pwdata,
    output logic      [kfd_pkg::PdataW-1:0] prdata,
    output logic                            pready
);
    import kfd_pkg::*;

    t_cfg               r_cfg;
    t_state             r_st;
    t_res [MaxRes-1:0]  r_q;
    t_res [MaxRes-1:0]  n_q;
    logic [CntW-1:0]    r_cnt;
    logic [CntW-1:0]    n_cnt;
    t_dec               dec;
    logic               acc;
    logic               take;
    logic               wr;

    kfd_parser u_parser (
        .i_rx_byte   (i_in.rx_byte),
        .i_rig_ready (i_in.rig_ready),
        .i_cfg       (r_cfg),
        .i_st        (r_st),
        .o_dec       (dec)
    );

    assign take = o_out.valid && o_out.ready;
    assign i_in.ready = (r_cnt == '0) || ((r_cnt == CntW'(1)) && o_out.ready);
    assign acc  = i_in.valid && i_in.ready;

    assign o_out.valid = (r_cnt != '0);
    assign o_out.kind  = r_q[0].kind;
    assign o_out.value = r_q[0].value;
    assign o_out.last  = (r_cnt == CntW'(1));

    always_comb begin
        n_cnt = r_cnt;
        n_q   = r_q;
        if (acc) begin
            n_cnt = dec.cnt;
            n_q   = dec.res;
        end else if (take) begin
            n_cnt = r_cnt - CntW'(1);
            n_q   = r_q >> $bits(t_res);
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign wr     = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt                <= '0;
            r_st.parse_state     <= ST_START;
            r_st.payload_type    <= PT_NONE;
            r_st.raw_idle        <= 1'b1;
            r_cfg.kiss_off       <= 1'b0;
            r_cfg.raw_prefix_on  <= 1'b0;
            r_cfg.reboot_code    <= REBOOT_RESET;
        end else begin
            r_cnt <= n_cnt;
            if (acc) r_st <= dec.nxt;
            if (wr) begin
                unique case (paddr[3:2])
                    REG_KISS_OFF:    r_cfg.kiss_off      <= pwdata[0];
                    REG_RAW_PREFIX:  r_cfg.raw_prefix_on <= pwdata[0];
                    REG_REBOOT_CODE: r_cfg.reboot_code   <= pwdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_KISS_OFF:    prdata = PdataW'(r_cfg.kiss_off);
            REG_RAW_PREFIX:  prdata = PdataW'(r_cfg.raw_prefix_on);
            REG_REBOOT_CODE: prdata = PdataW'(r_cfg.reboot_code);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* design/kfd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module kfd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [3:0] i_out_kind,
    input wire logic [7:0] i_out_value,
    input wire logic       i_out_last
);
    import kfd_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_value) && $stable(i_out_last))
        else $error("stalled result changed");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // refused, end, ctrl end, reboot, set p and set slot events always close their byte
    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == K_REFUSED || i_out_kind == K_END
            || i_out_kind == K_CTRL_END || i_out_kind == K_REBOOT
            || i_out_kind == K_SET_P || i_out_kind == K_SET_SLOT) |-> i_out_last)
        else $error("closing event not marked last");

    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == K_BEGIN || i_out_kind == K_END
            || i_out_kind == K_CTRL_END || i_out_kind == K_REBOOT
            || i_out_kind == K_REFUSED) |-> i_out_value == 8'h00)
        else $error("event without byte carries a value");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_kind <= K_REFUSED)
        else $error("result kind out of range");

endmodule

bind kiss_frame_decoder kfd_checker u_kfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_value (o_out.value),
    .i_out_last  (o_out.last)
);

`default_nettype wire

/* tb/tb_kiss_frame_decoder.sv */
`timescale 1ns / 1ps

module tb_kiss_frame_decoder;
    import kfd_pkg::*;

    localparam int StallLimit = 2000;
    localparam int NumDirected = 36;
    localparam int PhaseBytes = 12;

    typedef struct packed {
        logic [7:0] data;
        logic       rig_ready;
        logic       typed;
        logic       has_res;
        logic [3:0] kind;
        logic [7:0] value;
    } t_host_byte;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] value;
        logic       last;
    } t_event;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic              in_valid = 1'b0;
    logic [7:0]        in_data = 8'h00;
    logic              in_rig = 1'b0;
    logic              ev_ready = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [PaddrW-1:0] paddr = '0;
    logic [PdataW-1:0] pwdata = '0;
    logic [PdataW-1:0] prdata;
    logic              pready;

    kfd_in_if  host_if ();
    kfd_out_if ev_if ();

    assign host_if.valid     = in_valid;
    assign host_if.rx_byte   = in_data;
    assign host_if.rig_ready = in_rig;
    assign ev_if.ready       = ev_ready;

    kiss_frame_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (host_if.sink),
        .o_out   (ev_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // deframer state and register copies
    logic       cfg_kiss_off = 1'b0;
    logic       cfg_raw_prefix = 1'b0;
    logic [7:0] cfg_reboot = REBOOT_RESET;
    logic [2:0] parse_st = ST_START;
    logic [1:0] payload = PT_NONE;
    logic       raw_idle = 1'b1;

    t_res       step_events[$];
    t_event     pending_events[$];
    t_host_byte host_bytes[$];
    t_host_byte cur_byte = '0;
    t_event     want;

    bit steady = 1'b0;
    bit byte_taken = 1'b0;
    int stim_total = 0;
    int bytes_taken = 0;
    int events_seen = 0;
    int settings_run = 0;
    int errors = 0;
    int idle_cycles = 0;

    t_host_byte directed_rows [NumDirected] = '{
        '{8'h00,        1'b1, 1'b1, 1'b0, K_BEGIN,    8'h00}, // ignored before fend
        '{FEND,         1'b1, 1'b1, 1'b0, K_BEGIN,    8'h00},
        '{FEND,         1'b0, 1'b1, 1'b0, K_BEGIN,    8'h00}, // repeated fend
        '{CMD_DATA,     1'b0, 1'b1, 1'b1, K_REFUSED,  8'h00},
        '{CMD_DATA,     1'b1, 1'b1, 1'b1, K_BEGIN,    8'h00},
        '{8'hFF,        1'b0, 1'b1, 1'b1, K_DATA,     8'hFF},
        '{FESC,         1'b1, 1'b0, 1'b0, K_BEGIN,    8'h00},
        '{FEND,         1'b1, 1'b1, 1'b0, K_BEGIN,    8'h00}, // escape stays pending
        '{TFEND,        1'b0, 1'b1, 1'b1, K_DATA,     FEND},
        '{FESC,         1'b1, 1'b0, 1'b0, K_BEGIN,    8'h00},
        '{TFESC,        1'b1, 1'b1, 1'b1, K_DATA,     FESC},
        '{FEND,         1'b0, 1'b1, 1'b1, K_END,      8'h00},
        '{FEND,         1'b1, 1'b0, 1'b0, K_BEGIN,    8'h00},
        '{CMD_HW,       1'b0, 1'b0, 1'b0, K_BEGIN,    8'h00},
        '{8'h00,        1'b1, 1'b1, 1'b1, K_CTRL,     8'h00},
        '{FEND,         1'b1, 1'b1, 1'b1, K_CTRL_END, 8'h00},
        '{FEND,         1'b1, 1'b0, 1'b0, K_BEGIN,    8'h00},
        '{REBOOT_RESET, 1'b1, 1'b0, 1'b0, K_BEGIN,    8'h00},
        '{8'h12,        1'b0, 1'b1, 1'b0, K_BEGIN,    8'h00}, // reboot payload dropped
        '{FEND,         1'b1, 1'b1, 1'b1, K_REBOOT,   8'h00},
        '{FEND,         1'b1, 1'b0, 1'b0, K_BEGIN,    8'h00},
        '{CMD_P,        1'b1, 1'b0, 1'b0, K_BEGIN,    8'h00},
        '{FEND,         1'b1, 1'b1, 1'b1, K_SET_P,    FEND},  // value taken as is
        '{FEND,         1'b1, 1'b0, 1'b0, K_BEGIN,    8'h00},
        '{FEND,         1'b1, 1'b0, 1'b0, K_BEGIN,    8'h00},
        '{CMD_SLOT,     1'b0, 1'b0, 1'b0, K_BEGIN,    8'h00},
        '{8'hFF,        1'b1, 1'b1, 1'b1, K_SET_SLOT, 8'hFF},
        '{FEND,         1'b1, 1'b0, 1'b0, K_BEGIN,    8'h00},
        '{FEND,         1'b1, 1'b0, 1'b0, K_BEGIN,    8'h00},
        '{8'h77,        1'b1, 1'b0, 1'b0, K_BEGIN,    8'h00}, // unknown command
        '{FEND,         1'b1, 1'b1, 1'b0, K_BEGIN,    8'h00},
        '{FEND,         1'b1, 1'b0, 1'b0, K_BEGIN,    8'h00},
        '{CMD_DATA,     1'b1, 1'b1, 1'b1, K_BEGIN,    8'h00},
        '{FESC,         1'b1, 1'b0, 1'b0, K_BEGIN,    8'h00},
        '{8'h41,        1'b1, 1'b1, 1'b0, K_BEGIN,    8'h00}, // bad escape
        '{FEND,         1'b1, 1'b0, 1'b0, K_BEGIN,    8'h00}
    };

    function void add_event(logic [3:0] k, logic [7:0] v);
        t_res ev;
        ev.kind = k;
        ev.value = v;
        if (step_events.size() < MaxRes) step_events.insert(step_events.size(), ev);
    endfunction

    function void payload_event(logic [7:0] b);
        if (payload == PT_DATA) add_event(K_DATA, b);
        else if (payload == PT_CTRL) add_event(K_CTRL, b);
    endfunction

    function void deframe_byte(logic [7:0] b, logic rdy);
        step_events.delete();
        if (cfg_kiss_off) begin
            if (raw_idle) begin
                if (!rdy) begin
                    add_event(K_REFUSED, 8'h00);
                    return;
                end
                add_event(K_BEGIN, 8'h00);
                if (cfg_raw_prefix) begin
                    add_event(K_DATA, PREFIX_0);
                    add_event(K_DATA, PREFIX_1);
                    add_event(K_DATA, PREFIX_2);
                end
                raw_idle = 1'b0;
            end
            if (b == NEWLINE) begin
                add_event(K_END, 8'h00);
                raw_idle = 1'b1;
            end else begin
                add_event(K_DATA, b);
            end
        end else begin
            case (parse_st)
                ST_START: if (b == FEND) parse_st = ST_CMD;
                ST_END: if (b == FEND) parse_st = ST_START;
                ST_CMD: begin
                    // data and hardware win over the reboot code, which wins over the rest
                    if (b == CMD_DATA) begin
                        if (!rdy) begin
                            add_event(K_REFUSED, 8'h00);
                        end else begin
                            add_event(K_BEGIN, 8'h00);
                            parse_st = ST_DATA;
                            payload = PT_DATA;
                        end
                    end else if (b == CMD_HW) begin
                        parse_st = ST_DATA;
                        payload = PT_CTRL;
                    end else if (b == cfg_reboot) begin
                        parse_st = ST_DATA;
                        payload = PT_REBOOT;
                    end else if (b == CMD_P) begin
                        parse_st = ST_P;
                    end else if (b == CMD_SLOT) begin
                        parse_st = ST_SLOT;
                    end else if (b != FEND) begin
                        parse_st = ST_END;
                    end
                end
                ST_P: begin
                    add_event(K_SET_P, b);
                    parse_st = ST_END;
                end
                ST_SLOT: begin
                    add_event(K_SET_SLOT, b);
                    parse_st = ST_END;
                end
                ST_DATA: begin
                    if (b == FESC) begin
                        parse_st = ST_ESC;
                    end else if (b == FEND) begin
                        case (payload)
                            PT_DATA: add_event(K_END, 8'h00);
                            PT_CTRL: add_event(K_CTRL_END, 8'h00);
                            PT_REBOOT: add_event(K_REBOOT, 8'h00);
                            default: ;
                        endcase
                        parse_st = ST_START;
                    end else begin
                        payload_event(b);
                    end
                end
                ST_ESC: begin
                    if (b == TFEND) begin
                        payload_event(FEND);
                        parse_st = ST_DATA;
                    end else if (b == TFESC) begin
                        payload_event(FESC);
                        parse_st = ST_DATA;
                    end else if (b != FEND) begin
                        parse_st = ST_END;
                    end
                end
                default: parse_st = ST_START;
            endcase
        end
    endfunction

    function void queue_byte(logic [7:0] d, logic r);
        t_host_byte hb;
        hb = '0;
        hb.data = d;
        hb.rig_ready = r;
        hb.kind = K_BEGIN;
        host_bytes.insert(host_bytes.size(), hb);
        stim_total++;
    endfunction

    function logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function logic any_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function void queue_frame();
        int         sel;
        int         p;
        logic [7:0] cmd;
        sel = $urandom_range(0, 99);
        // some plain line noise between frames
        if (sel < 8) begin
            repeat ($urandom_range(1, 4)) queue_byte(any_byte(), any_bit());
            return;
        end
        queue_byte(FEND, any_bit());
        if ($urandom_range(0, 9) == 0) queue_byte(FEND, any_bit());
        sel = $urandom_range(0, 99);
        if (sel < 35) cmd = CMD_DATA;
        else if (sel < 50) cmd = CMD_HW;
        else if (sel < 62) cmd = cfg_reboot;
        else if (sel < 72) cmd = CMD_P;
        else if (sel < 82) cmd = CMD_SLOT;
        else cmd = any_byte();
        // radio busy on the first try, host retries
        if (cmd == CMD_DATA && $urandom_range(0, 99) < 15) queue_byte(cmd, 1'b0);
        queue_byte(cmd, 1'b1);
        if (cmd == CMD_P || cmd == CMD_SLOT) begin
            queue_byte(any_byte(), any_bit());
        end else begin
            repeat ($urandom_range(0, 6)) begin
                p = $urandom_range(0, 99);
                if (p < 12) begin
                    queue_byte(FESC, any_bit());
                    queue_byte(TFEND, any_bit());
                end else if (p < 22) begin
                    queue_byte(FESC, any_bit());
                    queue_byte(TFESC, any_bit());
                end else if (p < 26) begin
                    queue_byte(FESC, any_bit());
                    queue_byte(any_byte(), any_bit());
                end else begin
                    queue_byte(any_byte(), any_bit());
                end
            end
        end
        queue_byte(FEND, any_bit());
    endfunction

    function void queue_line();
        int         len;
        logic [7:0] b;
        len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        for (int i = 0; i <= len; i++) begin
            b = (i == len) ? NEWLINE : any_byte();
            if (i == 0 && $urandom_range(0, 99) < 15) queue_byte(b, 1'b0);
            queue_byte(b, (i == 0) ? 1'b1 : any_bit());
        end
    endfunction

    task automatic drain();
        while (bytes_taken != stim_total || pending_events.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [7:0] val);
        logic [PdataW-1:0] rd;
        logic [PdataW-1:0] exp_rd;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PaddrW'(4 * idx);
        pwdata <= PdataW'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_KISS_OFF: cfg_kiss_off = val[0];
            REG_RAW_PREFIX: cfg_raw_prefix = val[0];
            default: cfg_reboot = val;
        endcase
        exp_rd = (idx == REG_REBOOT_CODE) ? PdataW'(val) : PdataW'(val[0]);
        // read back
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd !== exp_rd) begin
            $error("prdata[%0d]: expected %0h, got %0h", idx, exp_rd, rd);
            errors++;
        end
    endtask

    task automatic run_setting(logic kiss_off, logic prefix, logic [7:0] code, bit no_gaps);
        int n0;
        cfg_write(REG_KISS_OFF, {7'd0, kiss_off});
        cfg_write(REG_RAW_PREFIX, {7'd0, prefix});
        cfg_write(REG_REBOOT_CODE, code);
        steady = no_gaps;
        n0 = stim_total;
        while (stim_total - n0 < PhaseBytes) begin
            if (kiss_off) queue_line();
            else queue_frame();
        end
        drain();
        settings_run++;
    endtask

    // host side: new item at the falling edge once the last one was taken, gaps unless steady
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || byte_taken)) begin
            if (host_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 16)) begin
                cur_byte <= host_bytes[0];
                in_data <= host_bytes[0].data;
                in_rig <= host_bytes[0].rig_ready;
                in_valid <= 1'b1;
                host_bytes.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) ev_ready <= steady || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge i_clk) begin
        byte_taken = 1'b0;
        if (i_rst_n) begin
            if (host_if.valid && host_if.ready) begin
                byte_taken = 1'b1;
                bytes_taken++;
                deframe_byte(host_if.rx_byte, host_if.rig_ready);
                if (cur_byte.typed) begin
                    if (cur_byte.has_res)
                        pending_events.insert(pending_events.size(),
                                              {cur_byte.kind, cur_byte.value, 1'b1});
                end else begin
                    foreach (step_events[i]) begin
                        pending_events.insert(pending_events.size(),
                                              {step_events[i].kind, step_events[i].value,
                                               i == step_events.size() - 1});
                    end
                end
            end
            if (ev_if.valid && ev_if.ready) begin
                events_seen++;
                if (pending_events.size() == 0) begin
                    $error("unexpected item: kind %0d value %0h last %0b",
                           ev_if.kind, ev_if.value, ev_if.last);
                    errors++;
                end else begin
                    want = pending_events.pop_front();
                    if (ev_if.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, ev_if.kind);
                        errors++;
                    end
                    if (ev_if.value !== want.value) begin
                        $error("value: expected %0h, got %0h", want.value, ev_if.value);
                        errors++;
                    end
                    if (ev_if.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, ev_if.last);
                        errors++;
                    end
                end
            end
            if (byte_taken || (ev_if.valid && ev_if.ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= StallLimit) begin
                $error("no item moved for %0d cycles, %0d results outstanding",
                       StallLimit, pending_events.size());
                $display("tb_kiss_frame_decoder NOT OK");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            host_bytes.insert(host_bytes.size(), directed_rows[i]);
            stim_total++;
        end
        drain();

        // reboot code at the extremes, on top of fend and on top of P
        run_setting(1'b0, 1'b0, 8'h00, 1'b0);
        run_setting(1'b1, 1'b0, 8'hFF, 1'b0);
        run_setting(1'b1, 1'b1, 8'hFF, 1'b1);
        run_setting(1'b0, 1'b1, FEND, 1'b0);
        run_setting(1'b0, 1'b0, CMD_P, 1'b0);
        run_setting(1'b1, 1'b1, any_byte(), 1'b0);
        run_setting(1'b0, 1'b0, any_byte(), 1'b0);

        $display("%0d host bytes sent over %0d register settings in kiss and raw line mode",
                 stim_total, settings_run);
        $display("%0d result items compared, %0d errors", events_seen, errors);
        if (errors == 0) begin
            $display("tb_kiss_frame_decoder OK");
        end else begin
            $display("tb_kiss_frame_decoder NOT OK");
        end
        $finish;
    end

endmodule
